### design/vpas_pkg.sv
// ----------------------------------------------------------------------------
// vpas_pkg
// Shared types and codes of the velocity PI unit: request and response
// payloads, configuration image, register map and multiply unit control.
// ----------------------------------------------------------------------------
package vpas_pkg;

  // request codes; code 3 is unused and reports the previous output unchanged
  localparam logic [1:0] REQ_UPDATE  = 2'd0;
  localparam logic [1:0] REQ_CLEAR   = 2'd1;
  localparam logic [1:0] REQ_PRELOAD = 2'd2;

  // register map, byte address 4*index
  localparam int ADDR_W = 5;
  typedef enum logic [2:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_CURRENT_LIMIT  = 3'd2,
    REG_VELOCITY_LIMIT = 3'd3,
    REG_SLEW_RATE      = 3'd4,
    REG_REVERSAL_SCALE = 3'd5
  } vpas_reg_e;

  // Q1.16 unity: scale values at or above it disable reversal decay
  localparam logic [16:0] SCALE_ONE = 17'd65536;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integ_gain;
    logic [30:0] current_limit;
    logic [30:0] velocity_limit;
    logic [30:0] slew_rate;
    logic [16:0] reversal_scale;
  } vpas_cfg_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] speed_target;
    logic signed [31:0] measured_velocity;
    logic [23:0]        step_time;
    logic               integ_enable;
    logic signed [31:0] preload_value;
  } vpas_req_t;

  typedef struct packed {
    logic signed [31:0] current_command;
    logic signed [31:0] prop_term;
    logic signed [31:0] unsat_command;
    logic signed [31:0] integ_value;
    logic               sat_event;
    logic               slew_event;
    logic               hold_event;
    logic               decay_event;
    logic [31:0]        sat_total;
    logic [31:0]        slew_total;
    logic [31:0]        hold_total;
    logic [31:0]        decay_total;
  } vpas_rsp_t;

  // multiply unit: b operand width and right shift choices
  localparam int MUL_B_W = 56;
  typedef enum logic [1:0] {
    SH_16 = 2'd0,
    SH_24 = 2'd1,
    SH_40 = 2'd2
  } vpas_shift_e;

  typedef struct packed {
    logic        start;
    logic        a_neg;
    logic [2:0]  nbytes;
    vpas_shift_e shift;
  } vpas_mul_cmd_t;

endpackage

### design/vpas_if.sv
// ----------------------------------------------------------------------------
// vpas_req_if / vpas_rsp_if
// Valid/ready channels carrying request and response payloads.
// ----------------------------------------------------------------------------
interface vpas_req_if import vpas_pkg::*; ();
  logic      valid;
  logic      ready;
  vpas_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vpas_rsp_if import vpas_pkg::*; ();
  logic      valid;
  logic      ready;
  vpas_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/vpas_regs.sv
// ----------------------------------------------------------------------------
// vpas_regs
// APB-style configuration registers, always ready, one register per word.
// ----------------------------------------------------------------------------
module vpas_regs import vpas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output vpas_cfg_t         cfg_o
);

  vpas_cfg_t cfg_q;
  logic      wr_en;
  vpas_reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = vpas_reg_e'(paddr[ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= '0;
      cfg_q.integ_gain     <= '0;
      cfg_q.current_limit  <= '0;
      cfg_q.velocity_limit <= '0;
      cfg_q.slew_rate      <= '0;
      cfg_q.reversal_scale <= SCALE_ONE;
    end else if (wr_en) begin
      unique case (sel)
        REG_PROP_GAIN:      cfg_q.prop_gain      <= pwdata;
        REG_INTEG_GAIN:     cfg_q.integ_gain     <= pwdata;
        REG_CURRENT_LIMIT:  cfg_q.current_limit  <= pwdata[30:0];
        REG_VELOCITY_LIMIT: cfg_q.velocity_limit <= pwdata[30:0];
        REG_SLEW_RATE:      cfg_q.slew_rate      <= pwdata[30:0];
        REG_REVERSAL_SCALE: cfg_q.reversal_scale <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_PROP_GAIN:      prdata = cfg_q.prop_gain;
      REG_INTEG_GAIN:     prdata = cfg_q.integ_gain;
      REG_CURRENT_LIMIT:  prdata = {1'b0, cfg_q.current_limit};
      REG_VELOCITY_LIMIT: prdata = {1'b0, cfg_q.velocity_limit};
      REG_SLEW_RATE:      prdata = {1'b0, cfg_q.slew_rate};
      REG_REVERSAL_SCALE: prdata = {15'd0, cfg_q.reversal_scale};
      default:            prdata = '0;
    endcase
  end

endmodule

### design/vpas_mul.sv
// ----------------------------------------------------------------------------
// vpas_mul
// Shared sign-magnitude multiplier: eight b bits per cycle into an exact
// product, then round half away from zero, shift and saturate.
// ----------------------------------------------------------------------------
module vpas_mul import vpas_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vpas_mul_cmd_t                 cmd_i,
  input  logic [VALUE_WIDTH-1:0]        a_mag_i,
  input  logic [MUL_B_W-1:0]            b_i,
  output logic                          done_o,
  output logic signed [VALUE_WIDTH-1:0] res_o,
  output logic [MUL_B_W-1:0]            raw_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int PW = W + MUL_B_W;
  localparam logic [PW:0] VMAX_U = ((PW+1)'(1) << (W - 1)) - (PW+1)'(1);

  typedef enum logic [1:0] {M_IDLE, M_ACC, M_RND, M_SAT} state_e;

  state_e               state_q;
  logic [W-1:0]         a_q;
  logic [MUL_B_W-1:0]   b_q;
  logic [2:0]           nby_q, idx_q;
  vpas_shift_e          sh_q;
  logic                 neg_q, done_q;
  logic [PW-1:0]        acc_q;
  logic [PW:0]          r_q;
  logic signed [W-1:0]  res_q;

  logic [7:0]    b_byte;
  logic [W+7:0]  pp;
  logic [PW-1:0] pp_sh;
  logic [PW:0]   rnd_sum, r_d;
  logic [W-1:0]  sat_d;

  always_comb begin
    b_byte = b_q[{idx_q, 3'b000} +: 8];
    pp     = a_q * b_byte;
    pp_sh  = PW'(pp) << {idx_q, 3'b000};
    case (sh_q)
      SH_24: begin
        rnd_sum = {1'b0, acc_q} + ((PW+1)'(1) << 23);
        r_d     = rnd_sum >> 24;
      end
      SH_40: begin
        rnd_sum = {1'b0, acc_q} + ((PW+1)'(1) << 39);
        r_d     = rnd_sum >> 40;
      end
      default: begin
        rnd_sum = {1'b0, acc_q} + ((PW+1)'(1) << 15);
        r_d     = rnd_sum >> 16;
      end
    endcase
    if (!neg_q) begin
      sat_d = (r_q > VMAX_U) ? {1'b0, {(W-1){1'b1}}} : r_q[W-1:0];
    end else begin
      sat_d = (r_q > VMAX_U + (PW+1)'(1)) ? {1'b1, {(W-1){1'b0}}}
                                           : (~r_q[W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      nby_q   <= '0;
      idx_q   <= '0;
      sh_q    <= SH_16;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      r_q     <= '0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (cmd_i.start) begin
            a_q     <= a_mag_i;
            b_q     <= b_i;
            nby_q   <= cmd_i.nbytes;
            sh_q    <= cmd_i.shift;
            neg_q   <= cmd_i.a_neg;
            acc_q   <= '0;
            idx_q   <= '0;
            state_q <= M_ACC;
          end
        end
        M_ACC: begin
          acc_q <= acc_q + pp_sh;
          idx_q <= idx_q + 3'd1;
          if (idx_q == nby_q - 3'd1) state_q <= M_RND;
        end
        M_RND: begin
          r_q     <= r_d;
          state_q <= M_SAT;
        end
        M_SAT: begin
          res_q   <= sat_d;
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign raw_o  = acc_q[MUL_B_W-1:0];

endmodule

### design/velocity_pi_antiwindup_slew_unit.sv
// ----------------------------------------------------------------------------
// velocity_pi_antiwindup_slew_unit
// Velocity PI controller with integrator anti-windup, reversal decay, current
// clamp and magnitude slew limit, producing a Q15.16 current command.
// ----------------------------------------------------------------------------
// One request is worked at a time; req ready is high only while the sequencer
// is idle. All products go through one shared multiplier that retires eight
// bits of its b operand per cycle and then rounds and saturates; a multiply
// holds the sequencer until the multiplier reports done. The b operand spans
// 4 bytes for prop, 4 for gain*dt, 3 for decay, 7 for the increment and 4 for
// the slew step. Clear and preload requests skip the multiplier. The sequencer
// returns to idle before it takes the next request.
// The result sits in an output register, so the next request is taken while a
// finished response still waits; a second finished response waits in the
// sequencer until the first one has gone.
// Internal values are saturated to VALUE_WIDTH bits; outputs saturate to 32.
module velocity_pi_antiwindup_slew_unit import vpas_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vpas_req_if.sink          req_ch,
  vpas_rsp_if.source        rsp_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int W  = VALUE_WIDTH;
  // working width: room for sums of two values and for 32-bit inputs
  localparam int XW = ((W > 32) ? W : 32) + 2;
  localparam logic signed [XW-1:0] VMAX_X  = (XW'(1) <<< (W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] VMIN_X  = -VMAX_X - XW'(1);
  localparam logic signed [XW-1:0] O32_MAX = XW'(2147483647);
  localparam logic signed [XW-1:0] O32_MIN = -O32_MAX - XW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_FRONT, S_M_PROP, S_M_GDT, S_DEC, S_M_DECAY, S_M_INC, S_HOLD,
    S_UNSAT, S_M_SLEW, S_SLEW, S_RECALC, S_RECALC2, S_FIN, S_OUT
  } state_e;

  // ---- helpers -------------------------------------------------------------
  function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] x);
    if (x > VMAX_X)      sat_x = VMAX_X[W-1:0];
    else if (x < VMIN_X) sat_x = VMIN_X[W-1:0];
    else                 sat_x = x[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] clamp_rng(input logic signed [W-1:0] x,
                                                    input logic signed [XW-1:0] lo,
                                                    input logic signed [XW-1:0] hi);
    logic signed [XW-1:0] xx;
    xx = XW'(x);
    if (xx < lo)      clamp_rng = lo[W-1:0];
    else if (xx > hi) clamp_rng = hi[W-1:0];
    else              clamp_rng = x;
  endfunction

  function automatic logic signed [W-1:0] clamp_lim(input logic signed [W-1:0] x,
                                                    input logic signed [W-1:0] lim);
    clamp_lim = clamp_rng(x, -XW'(lim), XW'(lim));
  endfunction

  function automatic logic is_pos(input logic signed [W-1:0] x);
    is_pos = !x[W-1] && (x != '0);
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
    mag = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [31:0] out32(input logic signed [W-1:0] x);
    logic signed [XW-1:0] xx;
    xx = XW'(x);
    if (xx > O32_MAX)      out32 = O32_MAX[31:0];
    else if (xx < O32_MIN) out32 = O32_MIN[31:0];
    else                   out32 = xx[31:0];
  endfunction

  // ---- configuration -------------------------------------------------------
  vpas_cfg_t cfg;

  vpas_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic signed [W-1:0] ilim, vlim;
  assign ilim = sat_x(XW'($signed({1'b0, cfg.current_limit})));
  assign vlim = sat_x(XW'($signed({1'b0, cfg.velocity_limit})));

  // ---- state ---------------------------------------------------------------
  state_e state_q, state_d;
  logic   issued_q, issued_d;
  logic [1:0]          rtype_q, rtype_d;
  logic signed [31:0]  tv_q, tv_d, mv_q, mv_d, pre_q, pre_d;
  logic [23:0]         dt_q, dt_d;
  logic                ien_q, ien_d;
  logic signed [W-1:0] err_q, err_d, prop_q, prop_d, integ_q, integ_d;
  logic signed [W-1:0] base_q, base_d, cand_q, cand_d, unsat_q, unsat_d;
  logic signed [W-1:0] cmd_q, cmd_d, perr_q, perr_d, pout_q, pout_d;
  logic signed [W-1:0] md_q, md_d;
  logic [MUL_B_W-1:0]  gdt_q, gdt_d;
  logic [31:0]         satc_q, satc_d, slewc_q, slewc_d;
  logic [31:0]         holdc_q, holdc_d, decc_q, decc_d;
  logic                evs_q, evs_d, evw_q, evw_d, evh_q, evh_d, evd_q, evd_d;
  logic                ovalid_q, ovalid_d;
  vpas_rsp_t           rsp_q, rsp_d;

  // ---- shared multiplier ---------------------------------------------------
  vpas_mul_cmd_t       mcmd;
  logic [W-1:0]        m_a;
  logic [MUL_B_W-1:0]  m_b;
  logic                m_done;
  logic signed [W-1:0] m_res;
  logic [MUL_B_W-1:0]  m_raw;
  logic                mul_state;

  vpas_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (mcmd),
    .a_mag_i (m_a),
    .b_i     (m_b),
    .done_o  (m_done),
    .res_o   (m_res),
    .raw_o   (m_raw)
  );

  assign mul_state = (state_q == S_M_PROP) || (state_q == S_M_GDT) ||
                     (state_q == S_M_DECAY) || (state_q == S_M_INC) ||
                     (state_q == S_M_SLEW);

  always_comb begin
    mcmd.start  = mul_state && !issued_q;
    mcmd.a_neg  = 1'b0;
    mcmd.nbytes = 3'd4;
    mcmd.shift  = SH_16;
    m_a         = W'(dt_q);
    m_b         = MUL_B_W'(cfg.slew_rate);
    case (state_q)
      S_M_PROP: begin
        mcmd.a_neg = err_q[W-1];
        m_a        = mag(err_q);
        m_b        = MUL_B_W'(cfg.prop_gain);
      end
      S_M_GDT: begin
        m_b = MUL_B_W'(cfg.integ_gain);    // exact product, raw result used
      end
      S_M_DECAY: begin
        mcmd.a_neg  = integ_q[W-1];
        mcmd.nbytes = 3'd3;
        m_a         = mag(integ_q);
        m_b         = MUL_B_W'(cfg.reversal_scale);
      end
      S_M_INC: begin
        mcmd.a_neg  = err_q[W-1];
        mcmd.nbytes = 3'd7;
        mcmd.shift  = SH_40;
        m_a         = mag(err_q);
        m_b         = gdt_q;
      end
      default: begin
        mcmd.shift = SH_24;                // slew step, round half up
      end
    endcase
  end

  // ---- datapath terms ------------------------------------------------------
  logic signed [W-1:0]  target, err_new, cand_new, unsat_new, cmd_new;
  logic signed [W-1:0]  rng_cl, lim_a, lim_b, pre_cl;
  logic signed [XW-1:0] candout, plo, phi;
  logic                 rev, dabs_gt, hold_hit, decay_hit, dpos, dneg;

  always_comb begin
    target   = clamp_lim(sat_x(XW'(tv_q)), vlim);
    err_new  = sat_x(XW'(target) - XW'(sat_x(XW'(mv_q))));
    pre_cl   = clamp_lim(sat_x(XW'(pre_q)), ilim);
    // sign reversal of the error against the previous step, zero never counts
    decay_hit = ien_q && ((is_pos(err_q) && perr_q[W-1]) ||
                          (err_q[W-1] && is_pos(perr_q))) &&
                (cfg.reversal_scale < SCALE_ONE);
    cand_new = clamp_lim(sat_x(XW'(base_q) + XW'(m_res)), ilim);
    candout  = XW'(prop_q) + XW'(cand_q);
    hold_hit = ((candout > XW'(ilim)) && is_pos(err_q)) ||
               ((candout < -XW'(ilim)) && err_q[W-1]);
    unsat_new = sat_x(XW'(prop_q) + XW'(integ_q));
    cmd_new   = clamp_lim(unsat_new, ilim);
    // slew window around the previous output
    plo     = XW'(pout_q) - XW'(md_q);
    phi     = XW'(pout_q) + XW'(md_q);
    rng_cl  = clamp_rng(cmd_q, plo, phi);
    rev     = (is_pos(cmd_q) && pout_q[W-1]) || (cmd_q[W-1] && is_pos(pout_q));
    dabs_gt = mag(cmd_q) > mag(pout_q);
    lim_a   = rev ? '0 : (dabs_gt ? rng_cl : cmd_q);
    lim_b   = rev ? '0 : rng_cl;
    dpos    = !rev && (cmd_q > pout_q) && is_pos(err_q);
    dneg    = !rev && (cmd_q < pout_q) && err_q[W-1];
  end

  // ---- sequencer -----------------------------------------------------------
  always_comb begin
    state_d  = state_q;   issued_d = issued_q;
    rtype_d  = rtype_q;   tv_d = tv_q;   mv_d = mv_q;   pre_d = pre_q;
    dt_d     = dt_q;      ien_d = ien_q;
    err_d    = err_q;     prop_d = prop_q;   integ_d = integ_q;
    base_d   = base_q;    cand_d = cand_q;   unsat_d = unsat_q;
    cmd_d    = cmd_q;     perr_d = perr_q;   pout_d = pout_q;
    md_d     = md_q;      gdt_d = gdt_q;
    satc_d   = satc_q;    slewc_d = slewc_q; holdc_d = holdc_q; decc_d = decc_q;
    evs_d    = evs_q;     evw_d = evw_q;     evh_d = evh_q;     evd_d = evd_q;
    ovalid_d = ovalid_q;  rsp_d = rsp_q;

    if (rsp_ch.ready) ovalid_d = 1'b0;
    if (mcmd.start) issued_d = 1'b1;
    if (m_done)     issued_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_ch.valid) begin
          rtype_d = req_ch.data.req_type;
          tv_d    = req_ch.data.speed_target;
          mv_d    = req_ch.data.measured_velocity;
          dt_d    = req_ch.data.step_time;
          ien_d   = req_ch.data.integ_enable;
          pre_d   = req_ch.data.preload_value;
          prop_d  = '0;
          unsat_d = '0;
          evs_d   = 1'b0; evw_d = 1'b0; evh_d = 1'b0; evd_d = 1'b0;
          state_d = S_FRONT;
        end
      end
      S_FRONT: begin
        case (rtype_q)
          REQ_UPDATE: begin
            err_d   = err_new;
            state_d = S_M_PROP;
          end
          REQ_CLEAR: begin
            integ_d = '0; perr_d = '0; pout_d = '0; cmd_d = '0;
            satc_d  = '0; slewc_d = '0; holdc_d = '0; decc_d = '0;
            state_d = S_OUT;
          end
          REQ_PRELOAD: begin
            pout_d  = pre_cl;
            cmd_d   = pre_cl;
            state_d = S_OUT;
          end
          default: begin                   // unused code: report, no change
            cmd_d   = pout_q;
            state_d = S_OUT;
          end
        endcase
      end
      S_M_PROP: begin
        if (m_done) begin
          prop_d  = m_res;
          base_d  = integ_q;
          state_d = ien_q ? S_M_GDT : S_UNSAT;
        end
      end
      S_M_GDT: begin
        if (m_done) begin
          gdt_d   = m_raw;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = decay_hit ? S_M_DECAY : S_M_INC;
      end
      S_M_DECAY: begin
        if (m_done) begin
          base_d  = m_res;
          integ_d = m_res;
          decc_d  = decc_q + 32'd1;
          evd_d   = 1'b1;
          state_d = S_M_INC;
        end
      end
      S_M_INC: begin
        if (m_done) begin
          cand_d  = cand_new;
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        // integrator equals base here; hold keeps it
        if (hold_hit) begin
          holdc_d = holdc_q + 32'd1;
          evh_d   = 1'b1;
        end else begin
          integ_d = cand_q;
        end
        state_d = S_UNSAT;
      end
      S_UNSAT: begin
        unsat_d = unsat_new;
        cmd_d   = cmd_new;
        if (cmd_new != unsat_new) begin
          satc_d = satc_q + 32'd1;
          evs_d  = 1'b1;
        end
        state_d = ((cfg.slew_rate != '0) && (dt_q != '0)) ? S_M_SLEW : S_FIN;
      end
      S_M_SLEW: begin
        if (m_done) begin
          md_d    = m_res;
          state_d = S_SLEW;
        end
      end
      S_SLEW: begin
        state_d = S_FIN;
        if (lim_a != cmd_q) begin
          slewc_d = slewc_q + 32'd1;
          evw_d   = 1'b1;
          if (ien_q && (dpos || dneg) && (integ_q != base_q)) begin
            // roll the integrator back and redo the command
            integ_d = base_q;
            holdc_d = holdc_q + 32'd1;
            evh_d   = 1'b1;
            state_d = S_RECALC;
          end else begin
            cmd_d = lim_a;
          end
        end
      end
      S_RECALC: begin
        unsat_d = unsat_new;
        cmd_d   = cmd_new;
        state_d = S_RECALC2;
      end
      S_RECALC2: begin
        cmd_d   = lim_b;
        state_d = S_FIN;
      end
      S_FIN: begin
        perr_d  = err_q;
        pout_d  = cmd_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || rsp_ch.ready) begin
          rsp_d.current_command = out32(cmd_q);
          rsp_d.prop_term       = out32(prop_q);
          rsp_d.unsat_command   = out32(unsat_q);
          rsp_d.integ_value     = out32(integ_q);
          rsp_d.sat_event       = evs_q;
          rsp_d.slew_event      = evw_q;
          rsp_d.hold_event      = evh_q;
          rsp_d.decay_event     = evd_q;
          rsp_d.sat_total       = satc_q;
          rsp_d.slew_total      = slewc_q;
          rsp_d.hold_total      = holdc_q;
          rsp_d.decay_total     = decc_q;
          ovalid_d              = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;  issued_q <= 1'b0;
      rtype_q <= '0;  tv_q <= '0;  mv_q <= '0;  pre_q <= '0;
      dt_q    <= '0;  ien_q <= 1'b0;
      err_q   <= '0;  prop_q <= '0;  integ_q <= '0;
      base_q  <= '0;  cand_q <= '0;  unsat_q <= '0;
      cmd_q   <= '0;  perr_q <= '0;  pout_q <= '0;
      md_q    <= '0;  gdt_q <= '0;
      satc_q  <= '0;  slewc_q <= '0;  holdc_q <= '0;  decc_q <= '0;
      evs_q   <= 1'b0; evw_q <= 1'b0; evh_q <= 1'b0; evd_q <= 1'b0;
      ovalid_q <= 1'b0; rsp_q <= '0;
    end else begin
      state_q <= state_d;  issued_q <= issued_d;
      rtype_q <= rtype_d;  tv_q <= tv_d;  mv_q <= mv_d;  pre_q <= pre_d;
      dt_q    <= dt_d;     ien_q <= ien_d;
      err_q   <= err_d;    prop_q <= prop_d;  integ_q <= integ_d;
      base_q  <= base_d;   cand_q <= cand_d;  unsat_q <= unsat_d;
      cmd_q   <= cmd_d;    perr_q <= perr_d;  pout_q <= pout_d;
      md_q    <= md_d;     gdt_q <= gdt_d;
      satc_q  <= satc_d;   slewc_q <= slewc_d; holdc_q <= holdc_d; decc_q <= decc_d;
      evs_q   <= evs_d;    evw_q <= evw_d;    evh_q <= evh_d;    evd_q <= evd_d;
      ovalid_q <= ovalid_d; rsp_q <= rsp_d;
    end
  end

  assign req_ch.ready = (state_q == S_IDLE);
  assign rsp_ch.valid = ovalid_q;
  assign rsp_ch.data  = rsp_q;

endmodule

### design/vpas_checker.sv
// ----------------------------------------------------------------------------
// vpas_checker
// Port-level checks of the velocity PI unit, bound to the top level.
// ----------------------------------------------------------------------------
module vpas_checker import vpas_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      req_valid_i,
  input logic      req_ready_i,
  input logic      rsp_valid_i,
  input logic      rsp_ready_i,
  input vpas_rsp_t rsp_data_i
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response dropped or changed while stalled");

  // one request at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one in progress");

  // a new response only comes out of a busy sequencer
  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("response without a request in progress");

endmodule

bind velocity_pi_antiwindup_slew_unit vpas_checker u_vpas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_ch.valid),
  .req_ready_i (req_ch.ready),
  .rsp_valid_i (rsp_ch.valid),
  .rsp_ready_i (rsp_ch.ready),
  .rsp_data_i  (rsp_ch.data)
);
